>>> hw/rtl/bpu_pkg.sv
// bpu_pkg: shared types and constants of the bmp pixel unpacker
`timescale 1ns / 1ps
package bpu_pkg;

  // clamp limits of the image geometry
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W   = 13;  // width, height, column and row counters
  localparam int BIR_W   = 14;  // byte position inside a source row
  localparam int LEN_W   = BIR_W + 1;
  localparam int COORD_W = 12;  // output column and row
  localparam int NPIX_W  = 4;   // pixels carried by one queue entry, 1 to 8
  localparam int K_W     = 3;   // pixel index inside an entry

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int LVL_W      = 3;

  localparam logic [23:0] RGB_WHITE = 24'hff_ffff;
  localparam logic [23:0] RGB_BLACK = 24'h00_0000;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

  typedef enum logic [1:0] {
    KIND_PALETTE = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_START   = 2'd2,
    KIND_NONE    = 2'd3
  } bpu_kind_e;

  typedef enum logic [2:0] {
    MODE_1BPP  = 3'd0,
    MODE_4BPP  = 3'd1,
    MODE_8BPP  = 3'd2,
    MODE_24BPP = 3'd3,
    MODE_32BPP = 3'd4
  } bpu_mode_e;

  typedef enum logic [1:0] {
    CFG_DEPTH_MODE = 2'd0,
    CFG_WIDTH      = 2'd1,
    CFG_HEIGHT     = 2'd2
  } bpu_cfg_e;

  // one decoded data byte: up to eight pixels on consecutive columns
  typedef struct packed {
    logic                mono;      // pixels come from the bits of mono_bits
    logic [7:0]          mono_bits;
    logic [23:0]         color0;
    logic [23:0]         color1;
    logic [COORD_W-1:0]  column;    // column of the first pixel
    logic [COORD_W-1:0]  row;
    logic [NPIX_W-1:0]   npix;
    logic                done;      // last pixel of the entry ends the image
  } bpu_entry_t;

  typedef struct packed {
    logic       valid;
    bpu_entry_t entry;
  } bpu_push_t;

endpackage

>>> hw/rtl/bpu_in_if.sv
// bpu_in_if: input channel carrying palette writes, data bytes and image starts
`timescale 1ns / 1ps
interface bpu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;
  logic [7:0] data_byte;

  modport source (
    output valid, kind, palette_index, palette_red, palette_green, palette_blue,
           data_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, palette_index, palette_red, palette_green, palette_blue,
           data_byte,
    output ready
  );
endinterface

>>> hw/rtl/bpu_out_if.sv
// bpu_out_if: output channel carrying decoded rgba pixels
`timescale 1ns / 1ps
interface bpu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [7:0]  pixel_alpha;
  logic [11:0] pixel_column;
  logic [11:0] pixel_row;
  logic        last_of_run;
  logic        image_done;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha, pixel_column,
           pixel_row, last_of_run, image_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue, pixel_alpha, pixel_column,
           pixel_row, last_of_run, image_done,
    output ready
  );
endinterface

>>> hw/rtl/bmp_pixel_unpacker.sv
// bmp_pixel_unpacker: top level of the bmp pixel array decoder
// path: a data byte's pixels reach out_if through stage one, the queue
//   and the output register
// throughput: one input beat per cycle while out_if stays ready and each byte
//   yields at most one pixel; a byte of n pixels holds the output stage for n beats
// reset: row counters cleared, 24 bpp mode, width and height of one;
//   palette contents are kept unknown until written, no clearing pass
`timescale 1ns / 1ps
module bmp_pixel_unpacker #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpu_in_if.sink      in_if,
  bpu_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  import bpu_pkg::*;

  // front to queue: one entry per data byte that yields pixels
  bpu_push_t        push;
  // queue to back
  bpu_entry_t       head;
  logic             not_empty;
  logic             pop;
  // queue fill level, the front holds off beats when the queue could overflow
  logic [LVL_W-1:0] level;

  // front: config registers, palette memory, row and column tracking,
  // one registered stage that waits on the palette read
  bpu_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fifo_level_i (level),
    .push_o       (push)
  );

  // decouples byte intake from pixel emission
  bpu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .level_o     (level)
  );

  // back: walks each entry one pixel per beat into the output register
  bpu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .not_empty_i (not_empty),
    .pop_o       (pop),
    .out_if      (out_if)
  );

endmodule

>>> hw/rtl/bpu_front.sv
// bpu_front: config registers, palette memory, row counters and byte classification
`timescale 1ns / 1ps
module bpu_front #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bpu_in_if.sink                 in_if,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [12:0]            cfg_data_i,
  input  logic [bpu_pkg::LVL_W-1:0] fifo_level_i,
  output bpu_pkg::bpu_push_t     push_o
);
  import bpu_pkg::*;

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [2:0]       mode_q;
  logic [DIM_W-1:0] width_q, height_q;

  logic [BIR_W-1:0] bir_q, bir_d;
  logic [DIM_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] src_q, src_d;
  logic [23:0]      partial_q, partial_d;
  logic [1:0]       phase_q, phase_d;

  // stage one: byte classified, palette read in flight
  logic               s1_valid_q, s1_valid_d;
  logic               s1_mono_q, s1_pal_q;
  logic [7:0]         s1_byte_q;
  logic [23:0]        s1_rgb_q;
  logic [COORD_W-1:0] s1_col_q, s1_row_q;
  logic [NPIX_W-1:0]  s1_npix_q;
  logic               s1_done_q;
  logic               oob_a_q, oob_b_q;
  logic [23:0]        rd_a_q, rd_b_q;

  logic [23:0] pal_mem [PALETTE_DEPTH];

  logic             accept;
  logic             data_go;
  logic [DIM_W-1:0] w_c, h_c;
  logic [LEN_W-1:0] data_len, pitch, bir_inc;
  logic             in_data, row_end;
  logic [NPIX_W-1:0] cand, npix;
  logic [DIM_W-1:0] avail, col_sum;
  logic             emit_rgb;
  logic [23:0]      rgb_merge;
  logic [7:0]       addr_a8, addr_b8;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (fifo_level_i + LVL_W'(s1_valid_q)) < LVL_W'(FIFO_DEPTH);

  // clamp the geometry registers
  always_comb begin
    if (width_q == '0) begin
      w_c = DIM_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_c = DIM_W'(MAX_WIDTH);
    end else begin
      w_c = width_q;
    end
    if (height_q == '0) begin
      h_c = DIM_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_c = DIM_W'(MAX_HEIGHT);
    end else begin
      h_c = height_q;
    end
  end

  // data bytes per row and padded pitch
  always_comb begin
    unique case (mode_q)
      MODE_1BPP:  data_len = (LEN_W'(w_c) + LEN_W'(7)) >> 3;
      MODE_4BPP:  data_len = (LEN_W'(w_c) + LEN_W'(1)) >> 1;
      MODE_8BPP:  data_len = LEN_W'(w_c);
      MODE_24BPP: data_len = (LEN_W'(w_c) << 1) + LEN_W'(w_c);
      MODE_32BPP: data_len = LEN_W'(w_c) << 2;
      default:    data_len = '0;
    endcase
    pitch = (data_len + LEN_W'(3)) & ~LEN_W'(3);
  end

  assign data_go = accept && (in_if.kind == KIND_DATA) && (mode_q <= MODE_32BPP)
                && (src_q < h_c);
  assign bir_inc = LEN_W'(bir_q) + LEN_W'(1);
  assign row_end = bir_inc >= pitch;
  assign in_data = LEN_W'(bir_q) < data_len;
  assign emit_rgb = ((mode_q == MODE_24BPP) && (phase_q >= 2'd2))
                 || ((mode_q == MODE_32BPP) && (phase_q == 2'd3));

  // gathered b, g, r bytes including the byte of this beat
  always_comb begin
    rgb_merge = partial_q;
    unique case (phase_q)
      2'd0: rgb_merge[7:0]   = in_if.data_byte;
      2'd1: rgb_merge[15:8]  = in_if.data_byte;
      2'd2: rgb_merge[23:16] = in_if.data_byte;
      default: rgb_merge = partial_q;
    endcase
  end

  // pixel count of this byte, cut at the row width
  always_comb begin
    cand = '0;
    if (in_data) begin
      unique case (mode_q) inside
        MODE_1BPP:  cand = NPIX_W'(8);
        MODE_4BPP:  cand = NPIX_W'(2);
        MODE_8BPP:  cand = NPIX_W'(1);
        MODE_24BPP,
        MODE_32BPP: cand = emit_rgb ? NPIX_W'(1) : '0;
        default:    cand = '0;
      endcase
    end
    avail = (col_q < w_c) ? (w_c - col_q) : '0;
    npix  = (avail < DIM_W'(cand)) ? avail[NPIX_W-1:0] : cand;
    col_sum = col_q + DIM_W'(npix);
  end

  // counter updates
  always_comb begin
    bir_d = bir_q;
    col_d = col_q;
    src_d = src_q;
    partial_d = partial_q;
    phase_d = phase_q;
    if (accept && (in_if.kind == KIND_START)) begin
      bir_d = '0;
      col_d = '0;
      src_d = '0;
      partial_d = '0;
      phase_d = '0;
    end else if (data_go) begin
      col_d = col_sum;
      if (in_data && ((mode_q == MODE_24BPP) || (mode_q == MODE_32BPP))) begin
        partial_d = rgb_merge;
        phase_d = emit_rgb ? 2'd0 : phase_q + 2'd1;
      end
      if (row_end) begin
        bir_d = '0;
        col_d = '0;
        phase_d = '0;
        partial_d = '0;
        src_d = src_q + DIM_W'(1);
      end else begin
        bir_d = bir_inc[BIR_W-1:0];
      end
    end
  end

  assign s1_valid_d = data_go && (npix != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_24BPP;
      width_q    <= DIM_W'(1);
      height_q   <= DIM_W'(1);
      bir_q      <= '0;
      col_q      <= '0;
      src_q      <= '0;
      partial_q  <= '0;
      phase_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEPTH_MODE: mode_q   <= cfg_data_i[2:0];
          CFG_WIDTH:      width_q  <= cfg_data_i;
          CFG_HEIGHT:     height_q <= cfg_data_i;
          default:        ;
        endcase
      end
      bir_q      <= bir_d;
      col_q      <= col_d;
      src_q      <= src_d;
      partial_q  <= partial_d;
      phase_q    <= phase_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (data_go) begin
      s1_mono_q <= (mode_q == MODE_1BPP);
      s1_pal_q  <= (mode_q == MODE_4BPP) || (mode_q == MODE_8BPP);
      s1_byte_q <= in_if.data_byte;
      s1_rgb_q  <= rgb_merge;
      s1_col_q  <= col_q[COORD_W-1:0];
      s1_row_q  <= COORD_W'(h_c - DIM_W'(1) - src_q);
      s1_npix_q <= npix;
      s1_done_q <= (col_sum == w_c) && (src_q == h_c - DIM_W'(1));
    end
  end

  // palette memory, two read ports for the two nibbles of a 4 bpp byte
  assign addr_a8 = (mode_q == MODE_8BPP) ? in_if.data_byte : {4'h0, in_if.data_byte[7:4]};
  assign addr_b8 = {4'h0, in_if.data_byte[3:0]};

  always_ff @(posedge clk_i) begin
    if (accept && (in_if.kind == KIND_PALETTE) && (int'(in_if.palette_index) < PALETTE_DEPTH))
    begin
      pal_mem[in_if.palette_index[PAL_AW-1:0]] <=
        {in_if.palette_red, in_if.palette_green, in_if.palette_blue};
    end
    rd_a_q  <= pal_mem[addr_a8[PAL_AW-1:0]];
    rd_b_q  <= pal_mem[addr_b8[PAL_AW-1:0]];
    oob_a_q <= int'(addr_a8) >= PALETTE_DEPTH;
    oob_b_q <= int'(addr_b8) >= PALETTE_DEPTH;
  end

  always_comb begin
    push_o.valid           = s1_valid_q;
    push_o.entry.mono      = s1_mono_q;
    push_o.entry.mono_bits = s1_byte_q;
    push_o.entry.color0    = s1_pal_q ? (oob_a_q ? RGB_BLACK : rd_a_q) : s1_rgb_q;
    push_o.entry.color1    = oob_b_q ? RGB_BLACK : rd_b_q;
    push_o.entry.column    = s1_col_q;
    push_o.entry.row       = s1_row_q;
    push_o.entry.npix      = s1_npix_q;
    push_o.entry.done      = s1_done_q;
  end

endmodule

>>> hw/rtl/bpu_fifo.sv
// bpu_fifo: short queue of decoded byte entries between front and back
`timescale 1ns / 1ps
module bpu_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpu_pkg::bpu_push_t        push_i,
  input  logic                      pop_i,
  output bpu_pkg::bpu_entry_t       head_o,
  output logic                      not_empty_o,
  output logic [bpu_pkg::LVL_W-1:0] level_o
);
  import bpu_pkg::*;

  bpu_entry_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [LVL_W-1:0]   cnt_q;
  logic               do_pop;

  assign not_empty_o = cnt_q != '0;
  assign level_o     = cnt_q;
  assign head_o      = mem_q[rd_q];
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + LVL_W'(push_i.valid) - LVL_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

endmodule

>>> hw/rtl/bpu_back.sv
// bpu_back: expands queue entries into one pixel per beat behind an output register
`timescale 1ns / 1ps
module bpu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpu_pkg::bpu_entry_t head_i,
  input  logic                not_empty_i,
  output logic                pop_o,
  bpu_out_if.source           out_if
);
  import bpu_pkg::*;

  logic [K_W-1:0] k_q, k_d;
  logic           vld_q, vld_d;
  logic [23:0]    rgb_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic           last_q, done_q;

  logic           load, take, last_pix;
  logic [23:0]    rgb_c;

  assign load     = !vld_q || out_if.ready;
  assign take     = load && not_empty_i;
  assign last_pix = (NPIX_W'(k_q) + NPIX_W'(1)) == head_i.npix;
  assign pop_o    = take && last_pix;

  always_comb begin
    if (head_i.mono) begin
      rgb_c = head_i.mono_bits[K_W'(7) - k_q] ? RGB_WHITE : RGB_BLACK;
    end else if (k_q == '0) begin
      rgb_c = head_i.color0;
    end else begin
      rgb_c = head_i.color1;
    end
    vld_d = load ? not_empty_i : vld_q;
    k_d   = k_q;
    if (take) begin
      k_d = last_pix ? '0 : k_q + K_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      k_q   <= '0;
    end else begin
      vld_q <= vld_d;
      k_q   <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rgb_q  <= rgb_c;
      col_q  <= head_i.column + COORD_W'(k_q);
      row_q  <= head_i.row;
      last_q <= last_pix;
      done_q <= last_pix && head_i.done;
    end
  end

  assign out_if.valid        = vld_q;
  assign out_if.pixel_red    = rgb_q[23:16];
  assign out_if.pixel_green  = rgb_q[15:8];
  assign out_if.pixel_blue   = rgb_q[7:0];
  assign out_if.pixel_alpha  = ALPHA_OPAQUE;
  assign out_if.pixel_column = col_q;
  assign out_if.pixel_row    = row_q;
  assign out_if.last_of_run  = last_q;
  assign out_if.image_done   = done_q;

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for the bmp pixel unpacker, directed and random images
`timescale 1ns / 1ps
module tb_top;
  import bpu_pkg::*;

  // settle time before a register write, for the pipeline to go quiet
  localparam int SETTLE_CYCLES  = 8;
  // cycles with no beat on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BEATS   = 60;
  localparam int MAX_RUN        = 8;  // most pixels one data byte can yield

  // depth codes the block must ignore
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  typedef struct packed {
    bpu_kind_e  kind;
    logic [7:0] pal_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last_of_run;
    logic               image_done;
  } pixel_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [12:0] cfg_data;

  bpu_in_if  byte_if ();
  bpu_out_if pix_if ();

  bmp_pixel_unpacker uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (byte_if),
    .out_if     (pix_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // decoder mirror: palette, registers and row counters
  logic [23:0]      pal_mirror [256];
  bit               pal_written [256];
  logic [2:0]       depth_mode;
  logic [12:0]      width_reg;
  logic [12:0]      height_reg;
  logic [BIR_W-1:0] row_byte;
  logic [DIM_W-1:0] col_cnt;
  logic [DIM_W-1:0] src_row;
  logic [23:0]      pix_bytes;   // b in [7:0], g in [15:8], r in [23:16]
  logic [1:0]       phase;

  pixel_t run_q [$];             // pixels of the byte being decoded
  pixel_t expected_pixels [$];   // pixels still owed by the block

  int beats_sent;
  int pixels_checked;
  int images_started;
  int errors;
  int idle_cycles;
  int pixels_by_mode [5];
  bit calm_input;                // stretch of back-to-back input beats

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int clamp_dim(logic [12:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // data bytes in one source row under the current registers
  function automatic int row_data_len();
    int w;
    w = clamp_dim(width_reg, MAX_WIDTH);
    case (depth_mode)
      MODE_1BPP:  return (w + 7) >> 3;
      MODE_4BPP:  return (w + 1) >> 1;
      MODE_8BPP:  return w;
      MODE_24BPP: return w * 3;
      default:    return w * 4;
    endcase
  endfunction

  // rows are padded to a four byte boundary
  function automatic int row_pitch();
    return ((row_data_len() + 3) >> 2) << 2;
  endfunction

  task automatic clear_row();
    row_byte  = '0;
    col_cnt   = '0;
    phase     = '0;
    pix_bytes = '0;
  endtask

  // queue one pixel unless it falls past the last column or the run is full
  task automatic emit_pixel(input logic [23:0] rgb, input int w, input int h);
    pixel_t p;
    if (col_cnt >= w || run_q.size() >= MAX_RUN) return;
    p.red         = rgb[23:16];
    p.green       = rgb[15:8];
    p.blue        = rgb[7:0];
    p.alpha       = ALPHA_OPAQUE;
    p.column      = col_cnt[COORD_W-1:0];
    p.row         = COORD_W'(h - 1 - src_row);   // bottom-up source rows
    p.last_of_run = 1'b0;
    p.image_done  = (col_cnt == w - 1) && (src_row == h - 1);
    run_q.push_back(p);
    pixels_by_mode[depth_mode]++;
    col_cnt++;
  endtask

  // work out the pixels one accepted input beat should produce
  task automatic predict_beat(input in_beat_t b);
    int         w;
    int         h;
    int         len;
    logic [7:0] d;
    run_q.delete();
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    d = b.data_byte;
    case (b.kind)
      KIND_PALETTE: begin
        pal_mirror[b.pal_index]  = {b.pal_red, b.pal_green, b.pal_blue};
        pal_written[b.pal_index] = 1'b1;
      end
      KIND_START: begin
        clear_row();
        src_row = '0;
        images_started++;
      end
      KIND_DATA: begin
        // unused depth codes and bytes past the image move nothing
        if (depth_mode <= MODE_32BPP && src_row < h) begin
          len = row_data_len();
          if (row_byte < len) begin
            case (depth_mode)
              MODE_1BPP:
                for (int i = 7; i >= 0; i--) emit_pixel(d[i] ? RGB_WHITE : RGB_BLACK, w, h);
              MODE_4BPP: begin
                emit_pixel(pal_mirror[d[7:4]], w, h);
                emit_pixel(pal_mirror[d[3:0]], w, h);
              end
              MODE_8BPP: emit_pixel(pal_mirror[d], w, h);
              default: begin
                // a phase left at 3 by a depth change keeps the gathered bytes
                if (phase < 3) pix_bytes[phase*8 +: 8] = d;
                if ((depth_mode == MODE_24BPP && phase >= 2) ||
                    (depth_mode == MODE_32BPP && phase == 3)) begin
                  emit_pixel(pix_bytes, w, h);
                  phase = '0;
                end else begin
                  phase = phase + 1'b1;
                end
              end
            endcase
          end
          // row ends at the padded pitch, or past it after a register change
          if (row_byte + 1 >= row_pitch()) begin
            clear_row();
            src_row++;
          end else begin
            row_byte++;
          end
        end
      end
      default: ;  // unknown kind is dropped
    endcase
    if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
    foreach (run_q[i]) expected_pixels.push_back(run_q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_input || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // unused payload fields carry random values
  function automatic in_beat_t random_beat(bpu_kind_e k);
    in_beat_t b;
    b.kind      = k;
    b.pal_index = 8'($urandom);
    b.pal_red   = 8'($urandom);
    b.pal_green = 8'($urandom);
    b.pal_blue  = 8'($urandom);
    b.data_byte = 8'($urandom);
    return b;
  endfunction

  // drive one beat, hold it until accepted, then predict its pixels
  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid         <= 1'b1;
    byte_if.kind          <= b.kind;
    byte_if.palette_index <= b.pal_index;
    byte_if.palette_red   <= b.pal_red;
    byte_if.palette_green <= b.pal_green;
    byte_if.palette_blue  <= b.pal_blue;
    byte_if.data_byte     <= b.data_byte;
    do @(posedge clk_i); while (byte_if.ready !== 1'b1);
    beats_sent++;
    predict_beat(b);
  endtask

  task automatic send_data(input logic [7:0] d);
    in_beat_t b;
    b = random_beat(KIND_DATA);
    b.data_byte = d;
    // an 8 bpp byte is a palette index and must name a written entry
    if (depth_mode == MODE_8BPP && !pal_written[d]) b.data_byte = {4'h0, d[3:0]};
    send_beat(b);
  endtask

  task automatic send_ctrl(input bpu_kind_e k);
    send_beat(random_beat(k));
  endtask

  task automatic write_palette(input logic [7:0] idx, input logic [23:0] rgb);
    in_beat_t b;
    b = random_beat(KIND_PALETTE);
    b.pal_index = idx;
    {b.pal_red, b.pal_green, b.pal_blue} = rgb;
    send_beat(b);
  endtask

  // stop input, let every owed pixel drain and the pipeline go quiet
  task automatic settle_idle();
    byte_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input bpu_cfg_e idx, input logic [12:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEPTH_MODE: depth_mode = value[2:0];
      CFG_WIDTH:      width_reg  = value;
      CFG_HEIGHT:     height_reg = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [12:0] mode_word, input logic [12:0] width,
                           input logic [12:0] height);
    settle_idle();
    write_reg(CFG_DEPTH_MODE, mode_word);
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_HEIGHT, height);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset leaves 24 bpp, one by one image: one pixel, one pad byte, then nothing
  task automatic test_reset_defaults();
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'h5a);
    send_data(8'($urandom));   // padding
    send_data(8'($urandom));   // past the image
    send_ctrl(KIND_NONE);
    send_ctrl(KIND_START);
    send_data(8'hff);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'($urandom));
  endtask

  // the low sixteen entries cover every nibble lookup, 8 bpp bytes stay on written entries
  task automatic test_palette_fill();
    for (int i = 0; i < 16; i++) begin
      if (i == 0) write_palette(8'(i), RGB_BLACK);
      else write_palette(8'(i), 24'($urandom));
    end
    write_palette(8'hff, RGB_WHITE);
  endtask

  // 1 bpp, width 11: second byte of each row is cut to three pixels
  task automatic test_mono();
    configure(MODE_1BPP, 13'd11, 13'd2);
    send_ctrl(KIND_START);
    send_data(8'ha5);
    send_data(8'he0);
    send_data(8'($urandom));
    send_data(8'($urandom));
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'($urandom));
    send_data(8'($urandom));
  endtask

  // 4 bpp, width 3: high nibble first, second byte only half used
  task automatic test_nibble();
    configure(MODE_4BPP, 13'd3, 13'd1);
    send_ctrl(KIND_START);
    send_data(8'h0f);
    send_data(8'hf3);
    send_data(8'($urandom));
    send_data(8'($urandom));
  endtask

  task automatic test_indexed();
    configure(MODE_8BPP, 13'd5, 13'd1);
    send_ctrl(KIND_START);
    send_data(8'h00);
    send_data(8'hff);
    repeat (6) send_data(8'($urandom));
  endtask

  // 32 bpp: the alpha byte is dropped, output alpha stays opaque
  task automatic test_truecolor32();
    configure(MODE_32BPP, 13'd2, 13'd1);
    send_ctrl(KIND_START);
    send_data(8'h00);
    send_data(8'hff);
    repeat (6) send_data(8'($urandom));
  endtask

  // zero and oversized geometry, and the start of a row of the widest image
  task automatic test_geometry_extremes();
    configure(MODE_8BPP, 13'd0, 13'h1fff);
    send_ctrl(KIND_START);
    repeat (4) send_data(8'($urandom));
    configure(MODE_1BPP, 13'h1fff, 13'd0);
    send_ctrl(KIND_START);
    repeat (8) send_data(8'($urandom));
  endtask

  task automatic test_odd_cases();
    // unused depth codes swallow data
    configure(MODE_UNUSED_LO, 13'd4, 13'd1);
    send_ctrl(KIND_START);
    repeat (3) send_data(8'($urandom));
    configure(MODE_UNUSED_HI, 13'd4, 13'd1);
    repeat (2) send_data(8'($urandom));
    // 32 bpp left at phase three, then switched to 24 bpp mid pixel
    configure(MODE_32BPP, 13'd2, 13'd1);
    send_ctrl(KIND_START);
    repeat (3) send_data(8'($urandom));
    settle_idle();
    write_reg(CFG_DEPTH_MODE, MODE_24BPP);
    repeat (5) send_data(8'($urandom));
    // width shrinks mid row so the next byte lands past the pitch
    configure(MODE_8BPP, 13'd8, 13'd2);
    send_ctrl(KIND_START);
    repeat (5) send_data(8'($urandom));
    settle_idle();
    write_reg(CFG_WIDTH, 13'd3);
    repeat (5) send_data(8'($urandom));
    // restart in the middle of a pixel
    configure(MODE_24BPP, 13'd2, 13'd1);
    send_ctrl(KIND_START);
    repeat (2) send_data(8'($urandom));
    send_ctrl(KIND_START);
    repeat (8) send_data(8'($urandom));
  endtask

  // small random images, mostly well formed, some cut short, overrun or noisy
  task automatic test_random_images();
    int          first_beat;
    int          nbytes;
    int          r;
    logic [2:0]  mode;
    logic [12:0] width;
    first_beat = beats_sent;
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 6) mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      else mode = 3'($urandom_range(MODE_1BPP, MODE_32BPP));
      r = $urandom_range(0, 99);
      if (r < 5) width = '0;
      else if (r < 85) width = 13'($urandom_range(1, 10));
      else width = 13'($urandom_range(11, 24));
      // upper bits of the depth word are not part of the register
      configure({10'($urandom), mode}, width, 13'($urandom_range(0, 3)));
      calm_input = ($urandom_range(0, 3) == 0);
      send_ctrl(KIND_START);
      if (depth_mode > MODE_32BPP) nbytes = $urandom_range(2, 6);
      else nbytes = clamp_dim(height_reg, MAX_HEIGHT) * row_pitch();
      r = $urandom_range(0, 99);
      if (r < 10) nbytes = $urandom_range(1, nbytes);
      else if (r < 20) nbytes += $urandom_range(1, 6);
      // the beat budget may cut the last image short
      for (int i = 0; i < nbytes && beats_sent - first_beat < RANDOM_BEATS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4) write_palette(8'($urandom), 24'($urandom));
        else if (r < 7) send_ctrl(KIND_NONE);
        else if (r < 8) send_ctrl(KIND_START);
        send_data(8'($urandom));
      end
    end
    calm_input = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // pixel checker
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel with nothing owed: column %0d row %0d", pix_if.pixel_column,
               pix_if.pixel_row);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_red", want.red, pix_if.pixel_red);
        check_field("pixel_green", want.green, pix_if.pixel_green);
        check_field("pixel_blue", want.blue, pix_if.pixel_blue);
        check_field("pixel_alpha", want.alpha, pix_if.pixel_alpha);
        check_field("pixel_column", want.column, pix_if.pixel_column);
        check_field("pixel_row", want.row, pix_if.pixel_row);
        check_field("last_of_run", want.last_of_run, pix_if.last_of_run);
        check_field("image_done", want.image_done, pix_if.image_done);
        pixels_checked++;
      end
    end
  end

  // output back-pressure: bursts of ready, mostly short stalls, a few long ones
  initial begin
    int burst;
    int stall;
    int r;
    pix_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      pix_if.ready <= 1'b1;
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      repeat (burst) @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 50) stall = 0;
      else if (r < 85) stall = $urandom_range(1, 3);
      else if (r < 97) stall = $urandom_range(4, 12);
      else stall = $urandom_range(30, 80);
      if (stall > 0) begin
        pix_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // hang detector: no beat accepted on either side for too long
  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    idle_cycles    = 0;
    errors         = 0;
    beats_sent     = 0;
    pixels_checked = 0;
    images_started = 0;
    calm_input     = 1'b0;
    foreach (pixels_by_mode[i]) pixels_by_mode[i] = 0;
    foreach (pal_written[i]) pal_written[i] = 1'b0;
    // mirror of the reset state
    depth_mode = MODE_24BPP;
    width_reg  = 13'd1;
    height_reg = 13'd1;
    clear_row();
    src_row = '0;

    rst_ni                <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= CFG_DEPTH_MODE;
    cfg_data              <= '0;
    byte_if.valid         <= 1'b0;
    byte_if.kind          <= KIND_NONE;
    byte_if.palette_index <= '0;
    byte_if.palette_red   <= '0;
    byte_if.palette_green <= '0;
    byte_if.palette_blue  <= '0;
    byte_if.data_byte     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_palette_fill();
    test_mono();
    test_nibble();
    test_indexed();
    test_truecolor32();
    test_geometry_extremes();
    test_odd_cases();
    test_random_images();
    settle_idle();

    $display("run: %0d beats in, %0d pixels checked, %0d image starts", beats_sent,
             pixels_checked, images_started);
    $display("pixels per depth 1/4/8/24/32 bpp: %0d %0d %0d %0d %0d", pixels_by_mode[0],
             pixels_by_mode[1], pixels_by_mode[2], pixels_by_mode[3], pixels_by_mode[4]);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/bpu_pkg.sv
hw/rtl/bpu_in_if.sv
hw/rtl/bpu_out_if.sv
hw/rtl/bpu_front.sv
hw/rtl/bpu_fifo.sv
hw/rtl/bpu_back.sv
hw/rtl/bmp_pixel_unpacker.sv
sim/tb_top.sv
